// ===== rtl/vfcm_pkg.sv =====
// vfcm_pkg: shared types, codes and lookup functions of the voxel face mesher
// no dependencies; used by the top unit, the datapath and the controller by scoped names

package vfcm_pkg;

  // command word, one per accepted input handshake
  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  pos_x;
    logic [5:0]  pos_y;
    logic [4:0]  pos_z;
    logic [7:0]  block_id;
    logic [7:0]  palette_index;
    logic [23:0] color_rgb;
  } vfcm_in_t;

  // vertex word, one per output handshake
  typedef struct packed {
    logic signed [7:0] vert_x;
    logic signed [7:0] vert_y;
    logic signed [7:0] vert_z;
    logic [2:0]        face_dir;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last_vertex;
  } vfcm_out_t;

  // command codes
  localparam logic [1:0] CMD_VOXEL_WR   = 2'd0;
  localparam logic [1:0] CMD_PALETTE_WR = 2'd1;
  localparam logic [1:0] CMD_MESH       = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_VERTEX_SCALE = 2'd2;

  localparam logic [5:0] GRID_WIDTH_RST   = 6'd32;
  localparam logic [6:0] GRID_HEIGHT_RST  = 7'd64;
  localparam logic [6:0] VERTEX_SCALE_RST = 7'd1;

  // face numbers as they appear on face_dir
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_PY = 3'd1;
  localparam logic [2:0] FACE_PZ = 3'd2;
  localparam logic [2:0] FACE_NX = 3'd3;
  localparam logic [2:0] FACE_NY = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // neighbour test slots in test order
  localparam logic [2:0] SLOT_PY = 3'd0;
  localparam logic [2:0] SLOT_PX = 3'd1;
  localparam logic [2:0] SLOT_PZ = 3'd2;
  localparam logic [2:0] SLOT_NY = 3'd3;
  localparam logic [2:0] SLOT_NX = 3'd4;
  localparam logic [2:0] SLOT_NZ = 3'd5;

  localparam logic [2:0] LAST_SLOT = 3'd5;
  localparam logic [2:0] LAST_VTX  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CENTRE,
    ST_PROBE,
    ST_PROBE_END,
    ST_EMIT
  } vfcm_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       vox_wr;
    logic       pal_wr;
    logic       cen_rd;
    logic       pal_rd;
    logic       probe_rd;
    logic [2:0] probe_slot;
    logic       emit;
    logic [2:0] vtx_idx;
  } vfcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       in_grid;
    logic       id_zero;
    logic       mask_empty;
    logic       last_face;
    logic       out_free;
  } vfcm_sts_t;

  function automatic logic [2:0] slot_face(input logic [2:0] slot);
    logic [2:0] f;
    case (slot)
      SLOT_PY: f = FACE_PY;
      SLOT_PX: f = FACE_PX;
      SLOT_PZ: f = FACE_PZ;
      SLOT_NY: f = FACE_NY;
      SLOT_NX: f = FACE_NX;
      SLOT_NZ: f = FACE_NZ;
      default: f = FACE_PX;
    endcase
    return f;
  endfunction

  // corner offset of one triangle vertex: bit 2 dx, bit 1 dy, bit 0 dz
  function automatic logic [2:0] corner_off(input logic [2:0] face, input logic [2:0] vtx);
    logic [17:0] row;
    logic [2:0]  c;
    case (face)
      FACE_PX: row = {3'd0, 3'd1, 3'd3, 3'd3, 3'd2, 3'd0};
      FACE_PY: row = {3'd5, 3'd1, 3'd0, 3'd0, 3'd4, 3'd5};
      FACE_PZ: row = {3'd0, 3'd2, 3'd6, 3'd6, 3'd4, 3'd0};
      FACE_NX: row = {3'd3, 3'd1, 3'd0, 3'd0, 3'd2, 3'd3};
      FACE_NY: row = {3'd0, 3'd1, 3'd5, 3'd5, 3'd4, 3'd0};
      FACE_NZ: row = {3'd6, 3'd2, 3'd0, 3'd0, 3'd4, 3'd6};
      default: row = '0;
    endcase
    case (vtx)
      3'd0:    c = row[2:0];
      3'd1:    c = row[5:3];
      3'd2:    c = row[8:6];
      3'd3:    c = row[11:9];
      3'd4:    c = row[14:12];
      3'd5:    c = row[17:15];
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/voxel_face_cull_mesher_unit.sv =====
// voxel_face_cull_mesher_unit: a write word, spare code or cell outside the grid ends after
// dispatch, an empty cell after the centre read; any other mesh word goes through six
// neighbour reads and a probe end step, then gives six vertices per exposed face, one a
// cycle while the sink is ready; a new command word is taken only in idle; the pace is set
// by the voxel memory's single read port (centre plus six neighbour reads) and output register
// reset: synchronous, clears sequencer, output valid and registers to 32 / 64 / 1; memories kept

module voxel_face_cull_mesher_unit #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 64,
  parameter int PALETTE_DEPTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  // command words
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  vfcm_pkg::vfcm_in_t  cmd_word,
  // vertex words
  output logic                vtx_valid,
  input  logic                vtx_ready,
  output vfcm_pkg::vfcm_out_t vtx_word,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [5:0] grid_width;
  logic [6:0] grid_height;
  logic [6:0] vertex_scale;
  logic       cfg_wr;

  vfcm_pkg::vfcm_cmd_t ctl;
  vfcm_pkg::vfcm_sts_t sts;

  // register port: no wait states, write lands in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= vfcm_pkg::GRID_WIDTH_RST;
      grid_height  <= vfcm_pkg::GRID_HEIGHT_RST;
      vertex_scale <= vfcm_pkg::VERTEX_SCALE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vfcm_pkg::REG_GRID_WIDTH:   grid_width   <= pwdata[5:0];
        vfcm_pkg::REG_GRID_HEIGHT:  grid_height  <= pwdata[6:0];
        vfcm_pkg::REG_VERTEX_SCALE: vertex_scale <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read back; unmapped addresses read as zero
  always_comb begin
    case (paddr[3:2])
      vfcm_pkg::REG_GRID_WIDTH:   prdata = 32'(grid_width);
      vfcm_pkg::REG_GRID_HEIGHT:  prdata = 32'(grid_height);
      vfcm_pkg::REG_VERTEX_SCALE: prdata = 32'(vertex_scale);
      default:                    prdata = 32'd0;
    endcase
  end

  // sequencer: dispatch, centre read, six neighbour reads, then emission
  vfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // memories, exposure mask, vertex maths and output register
  vfcm_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd_word     (cmd_word),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .vertex_scale (vertex_scale),
    .ctl          (ctl),
    .sts          (sts),
    .vtx_valid    (vtx_valid),
    .vtx_ready    (vtx_ready),
    .vtx_word     (vtx_word)
  );

  // no vertex is produced while a new command word can be taken
  a_no_emit_when_ready: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !cmd_ready)
    else $error("vertex emitted while accepting commands");

  // a waiting vertex is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && vtx_valid |-> vtx_ready)
    else $error("output register overwritten before it was taken");

  // datapath strobes are mutually exclusive
  a_strobes_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load_item, ctl.vox_wr, ctl.pal_wr, ctl.cen_rd, ctl.pal_rd,
              ctl.probe_rd, ctl.emit}))
    else $error("more than one datapath strobe active");

  // a valid vertex carries a real face number
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    vtx_valid |-> (vtx_word.face_dir != 3'd6) && (vtx_word.face_dir != 3'd7))
    else $error("face number out of range");

endmodule

// ===== rtl/vfcm_ram.sv =====
// vfcm_ram: generic single write, single read memory with registered read
// no dependencies

module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vfcm_datapath.sv =====
// vfcm_datapath: command register, voxel and palette memories, exposure mask,
// vertex arithmetic and output register; depends on vfcm_pkg and vfcm_ram

module vfcm_datapath #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 64,
  parameter int PALETTE_DEPTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  vfcm_pkg::vfcm_in_t  cmd_word,
  input  logic [5:0]          grid_width,
  input  logic [6:0]          grid_height,
  input  logic [6:0]          vertex_scale,
  input  vfcm_pkg::vfcm_cmd_t ctl,
  output vfcm_pkg::vfcm_sts_t sts,
  output logic                vtx_valid,
  input  logic                vtx_ready,
  output vfcm_pkg::vfcm_out_t vtx_word
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int VAW    = 2 * XW + YW;
  localparam int VDEPTH = 1 << VAW;
  localparam int PAW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [7:0] MAX_W8 = 8'(MAX_WIDTH);
  localparam logic [7:0] MAX_H8 = 8'(MAX_HEIGHT);
  localparam logic [7:0] PAL_D8 = 8'(PALETTE_DEPTH);

  vfcm_pkg::vfcm_in_t  item;
  vfcm_pkg::vfcm_out_t vtx_next;

  logic [7:0]     x8, y8, z8;
  logic [7:0]     w_eff, h_eff;
  logic           vox_in_store, pal_in_store;
  logic [7:0]     nx, ny, nz;
  logic           nb_edge;
  logic [VAW-1:0] vox_waddr, vox_raddr;
  logic [7:0]     vox_rdata;
  logic [7:0]     id_m1;
  logic [23:0]    pal_rdata;
  logic [23:0]    rgb;
  logic           col_ok;
  logic           probe_pend;
  logic [2:0]     probe_slot_q;
  logic           nb_edge_q;
  logic [5:0]     mask;
  logic [2:0]     cur_slot;
  logic [2:0]     face;
  logic [2:0]     corner;
  logic [7:0]     vx, vy, vz;
  logic [14:0]    prod_x, prod_z;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd_word;
    end
  end

  assign x8 = {3'b000, item.pos_x};
  assign y8 = {2'b00, item.pos_y};
  assign z8 = {3'b000, item.pos_z};

  // configured grid clamped to the store
  assign w_eff = ({2'b00, grid_width} < MAX_W8) ? {2'b00, grid_width} : MAX_W8;
  assign h_eff = ({1'b0, grid_height} < MAX_H8) ? {1'b0, grid_height} : MAX_H8;

  assign vox_in_store = (x8 < MAX_W8) && (z8 < MAX_W8) && (y8 < MAX_H8);
  assign pal_in_store = item.palette_index < PAL_D8;

  // neighbour address and grid edge for the slot under test
  always_comb begin
    nx      = x8;
    ny      = y8;
    nz      = z8;
    nb_edge = 1'b0;
    if (ctl.probe_rd) begin
      case (ctl.probe_slot)
        vfcm_pkg::SLOT_PY: begin
          ny      = y8 + 8'd1;
          nb_edge = (ny == h_eff);
        end
        vfcm_pkg::SLOT_PX: begin
          nx      = x8 + 8'd1;
          nb_edge = (nx == w_eff);
        end
        vfcm_pkg::SLOT_PZ: begin
          nz      = z8 + 8'd1;
          nb_edge = (nz == w_eff);
        end
        vfcm_pkg::SLOT_NY: begin
          ny      = y8 - 8'd1;
          nb_edge = (y8 == 8'd0);
        end
        vfcm_pkg::SLOT_NX: begin
          nx      = x8 - 8'd1;
          nb_edge = (x8 == 8'd0);
        end
        vfcm_pkg::SLOT_NZ: begin
          nz      = z8 - 8'd1;
          nb_edge = (z8 == 8'd0);
        end
        default: begin
          nb_edge = 1'b1;
        end
      endcase
    end
  end

  assign vox_waddr = {x8[XW-1:0], z8[XW-1:0], y8[YW-1:0]};
  assign vox_raddr = {nx[XW-1:0], nz[XW-1:0], ny[YW-1:0]};

  vfcm_ram #(
    .WIDTH (8),
    .DEPTH (VDEPTH)
  ) u_voxel_ram (
    .clk   (clk),
    .we    (ctl.vox_wr & vox_in_store),
    .waddr (vox_waddr),
    .wdata (item.block_id),
    .re    (ctl.cen_rd | ctl.probe_rd),
    .raddr (vox_raddr),
    .rdata (vox_rdata)
  );

  assign id_m1 = vox_rdata - 8'd1;

  vfcm_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette_ram (
    .clk   (clk),
    .we    (ctl.pal_wr & pal_in_store),
    .waddr (item.palette_index[PAW-1:0]),
    .wdata (item.color_rgb),
    .re    (ctl.pal_rd),
    .raddr (id_m1[PAW-1:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.pal_rd) begin
      col_ok <= id_m1 < PAL_D8;
    end
  end

  assign rgb = col_ok ? pal_rdata : 24'd0;

  // neighbour test: the id read for a slot is checked in the cycle after the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_pend <= 1'b0;
    end else begin
      probe_pend <= ctl.probe_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.probe_rd) begin
      probe_slot_q <= ctl.probe_slot;
      nb_edge_q    <= nb_edge;
    end
    if (probe_pend) begin
      mask[probe_slot_q] <= nb_edge_q | (vox_rdata == 8'd0);
    end else if (ctl.emit && (ctl.vtx_idx == vfcm_pkg::LAST_VTX)) begin
      mask[cur_slot] <= 1'b0;
    end
  end

  always_comb begin
    cur_slot = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        cur_slot = 3'(i);
      end
    end
  end

  assign face   = vfcm_pkg::slot_face(cur_slot);
  assign corner = vfcm_pkg::corner_off(face, ctl.vtx_idx);

  assign vx = x8 + {7'd0, face == vfcm_pkg::FACE_PX} + {7'd0, corner[2]};
  assign vy = y8 + {7'd0, face == vfcm_pkg::FACE_PY} + {7'd0, corner[1]};
  assign vz = z8 + {7'd0, face == vfcm_pkg::FACE_PZ} + {7'd0, corner[0]};

  assign prod_x = 15'(vx) * 15'(vertex_scale);
  assign prod_z = 15'(vz) * 15'(vertex_scale);

  always_comb begin
    vtx_next.vert_x      = prod_x[7:0];
    vtx_next.vert_y      = vy;
    vtx_next.vert_z      = prod_z[7:0];
    vtx_next.face_dir    = face;
    vtx_next.red         = rgb[23:16];
    vtx_next.green       = rgb[15:8];
    vtx_next.blue        = rgb[7:0];
    vtx_next.last_vertex = (ctl.vtx_idx == vfcm_pkg::LAST_VTX) && sts.last_face;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_valid <= 1'b0;
    end else if (ctl.emit) begin
      vtx_valid <= 1'b1;
    end else if (vtx_ready) begin
      vtx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      vtx_word <= vtx_next;
    end
  end

  always_comb begin
    sts.command    = item.command;
    sts.in_grid    = (x8 < w_eff) && (z8 < w_eff) && (y8 < h_eff);
    sts.id_zero    = (vox_rdata == 8'd0);
    sts.mask_empty = (mask == 6'd0);
    sts.last_face  = ((mask & (mask - 6'd1)) == 6'd0);
    sts.out_free   = !vtx_valid || vtx_ready;
  end

endmodule

// ===== rtl/vfcm_ctrl.sv =====
// vfcm_ctrl: sequencer for command dispatch, neighbour tests and emission
// depends on vfcm_pkg

module vfcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  vfcm_pkg::vfcm_sts_t sts,
  output vfcm_pkg::vfcm_cmd_t ctl
);

  vfcm_pkg::vfcm_state_t state, state_next;
  logic [2:0]            cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfcm_pkg::ST_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      vfcm_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = vfcm_pkg::ST_DISPATCH;
        end
      end
      vfcm_pkg::ST_DISPATCH: begin
        if ((sts.command == vfcm_pkg::CMD_MESH) && sts.in_grid) begin
          state_next = vfcm_pkg::ST_CENTRE;
        end else begin
          state_next = vfcm_pkg::ST_IDLE;
        end
      end
      vfcm_pkg::ST_CENTRE: begin
        cnt_next = 3'd0;
        if (sts.id_zero) begin
          state_next = vfcm_pkg::ST_IDLE;
        end else begin
          state_next = vfcm_pkg::ST_PROBE;
        end
      end
      vfcm_pkg::ST_PROBE: begin
        cnt_next = cnt + 3'd1;
        if (cnt == vfcm_pkg::LAST_SLOT) begin
          state_next = vfcm_pkg::ST_PROBE_END;
        end
      end
      vfcm_pkg::ST_PROBE_END: begin
        cnt_next   = 3'd0;
        state_next = vfcm_pkg::ST_EMIT;
      end
      vfcm_pkg::ST_EMIT: begin
        if (sts.mask_empty) begin
          state_next = vfcm_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          if (cnt == vfcm_pkg::LAST_VTX) begin
            cnt_next = 3'd0;
            if (sts.last_face) begin
              state_next = vfcm_pkg::ST_IDLE;
            end
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      default: begin
        state_next = vfcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl       = '0;
    cmd_ready = 1'b0;
    case (state)
      vfcm_pkg::ST_IDLE: begin
        cmd_ready     = 1'b1;
        ctl.load_item = cmd_valid;
      end
      vfcm_pkg::ST_DISPATCH: begin
        case (sts.command)
          vfcm_pkg::CMD_VOXEL_WR:   ctl.vox_wr = 1'b1;
          vfcm_pkg::CMD_PALETTE_WR: ctl.pal_wr = 1'b1;
          vfcm_pkg::CMD_MESH:       ctl.cen_rd = sts.in_grid;
          default: ;
        endcase
      end
      vfcm_pkg::ST_CENTRE: begin
        ctl.pal_rd = !sts.id_zero;
      end
      vfcm_pkg::ST_PROBE: begin
        ctl.probe_rd   = 1'b1;
        ctl.probe_slot = cnt;
      end
      vfcm_pkg::ST_EMIT: begin
        ctl.emit    = !sts.mask_empty && sts.out_free;
        ctl.vtx_idx = cnt;
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/vfcm_vertex_checker.sv =====
// vfcm_vertex_checker: watches the command, vertex and register ports of the voxel mesher,
// works out the vertex words of every accepted command word and compares them in order
// depends on vfcm_pkg for the word types, command codes, register indexes and face numbers

module vfcm_vertex_checker #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 64,
  parameter int PALETTE_DEPTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  vfcm_pkg::vfcm_in_t  cmd_word,
  input  logic                vtx_valid,
  input  logic                vtx_ready,
  input  vfcm_pkg::vfcm_out_t vtx_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  mismatch_count,
  output int                  vertices_pending
);

  localparam int CELLS = MAX_WIDTH * MAX_WIDTH * MAX_HEIGHT;

  logic [7:0]          voxel_mem   [0:CELLS-1];
  logic [23:0]         palette_mem [0:PALETTE_DEPTH-1];
  logic [5:0]          width_reg;
  logic [6:0]          height_reg;
  logic [6:0]          scale_reg;
  vfcm_pkg::vfcm_out_t vertex_queue [$];
  vfcm_pkg::vfcm_out_t cell_verts   [$];
  int                  mismatches = 0;

  function automatic int cell_index(input int x, input int y, input int z);
    return (x * MAX_WIDTH + z) * MAX_HEIGHT + y;
  endfunction

  function automatic bit cell_clear(input int x, input int y, input int z);
    return voxel_mem[cell_index(x, y, z)] == 8'd0;
  endfunction

  // corners of the two triangles, vertex 0 in the top bits; bit 2 dx, bit 1 dy, bit 0 dz
  function automatic logic [17:0] corner_row(input logic [2:0] face);
    case (face)
      vfcm_pkg::FACE_PX: return {3'd0, 3'd2, 3'd3, 3'd3, 3'd1, 3'd0};
      vfcm_pkg::FACE_PY: return {3'd5, 3'd4, 3'd0, 3'd0, 3'd1, 3'd5};
      vfcm_pkg::FACE_PZ: return {3'd0, 3'd4, 3'd6, 3'd6, 3'd2, 3'd0};
      vfcm_pkg::FACE_NX: return {3'd3, 3'd2, 3'd0, 3'd0, 3'd1, 3'd3};
      vfcm_pkg::FACE_NY: return {3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0};
      default:           return {3'd6, 3'd4, 3'd0, 3'd0, 3'd2, 3'd6};
    endcase
  endfunction

  function automatic void add_face(input int bx, input int by, input int bz,
                                   input logic [2:0] face, input logic [23:0] rgb);
    logic [17:0]         row;
    logic [2:0]          c;
    int                  t;
    vfcm_pkg::vfcm_out_t v;
    row = corner_row(face);
    for (int i = 0; i < 6; i++) begin
      c = row[17 - 3 * i -: 3];
      t = (bx + int'(c[2])) * int'(scale_reg);
      v.vert_x = t[7:0];
      t = by + int'(c[1]);
      v.vert_y = t[7:0];
      t = (bz + int'(c[0])) * int'(scale_reg);
      v.vert_z = t[7:0];
      v.face_dir    = face;
      v.red         = rgb[23:16];
      v.green       = rgb[15:8];
      v.blue        = rgb[7:0];
      v.last_vertex = 1'b0;
      cell_verts.insert(cell_verts.size(), v);
    end
  endfunction

  function automatic void mesh_cell(input vfcm_pkg::vfcm_in_t w);
    int                  wd, ht, x, y, z, slot;
    logic [23:0]         rgb;
    vfcm_pkg::vfcm_out_t v;
    wd = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    ht = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    x  = w.pos_x;
    y  = w.pos_y;
    z  = w.pos_z;
    if (x >= wd || z >= wd || y >= ht) return;
    if (voxel_mem[cell_index(x, y, z)] == 8'd0) return;
    slot = int'(voxel_mem[cell_index(x, y, z)]) - 1;
    rgb  = (slot < PALETTE_DEPTH) ? palette_mem[slot] : 24'd0;
    cell_verts.delete();
    if (y + 1 == ht || cell_clear(x, y + 1, z))
      add_face(x, y + 1, z, vfcm_pkg::FACE_PY, rgb);
    if (x + 1 == wd || cell_clear(x + 1, y, z))
      add_face(x + 1, y, z, vfcm_pkg::FACE_PX, rgb);
    if (z + 1 == wd || cell_clear(x, y, z + 1))
      add_face(x, y, z + 1, vfcm_pkg::FACE_PZ, rgb);
    if (y == 0 || cell_clear(x, y - 1, z)) add_face(x, y, z, vfcm_pkg::FACE_NY, rgb);
    if (x == 0 || cell_clear(x - 1, y, z)) add_face(x, y, z, vfcm_pkg::FACE_NX, rgb);
    if (z == 0 || cell_clear(x, y, z - 1)) add_face(x, y, z, vfcm_pkg::FACE_NZ, rgb);
    if (cell_verts.size() > 0) begin
      v = cell_verts[cell_verts.size() - 1];
      v.last_vertex = 1'b1;
      cell_verts[cell_verts.size() - 1] = v;
    end
    foreach (cell_verts[i]) vertex_queue.insert(vertex_queue.size(), cell_verts[i]);
  endfunction

  function automatic void take_word(input vfcm_pkg::vfcm_in_t w);
    case (w.command)
      vfcm_pkg::CMD_VOXEL_WR: begin
        if (w.pos_x < MAX_WIDTH && w.pos_z < MAX_WIDTH && w.pos_y < MAX_HEIGHT)
          voxel_mem[cell_index(w.pos_x, w.pos_y, w.pos_z)] = w.block_id;
      end
      vfcm_pkg::CMD_PALETTE_WR: begin
        if (w.palette_index < PALETTE_DEPTH) palette_mem[w.palette_index] = w.color_rgb;
      end
      vfcm_pkg::CMD_MESH: mesh_cell(w);
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t vertex %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_vertex(input vfcm_pkg::vfcm_out_t got);
    vfcm_pkg::vfcm_out_t want;
    if (vertex_queue.size() == 0) begin
      mismatches++;
      $display("%0t vertex word: expected none, got %h", $time, got);
      return;
    end
    want = vertex_queue.pop_front();
    check_field("x", want.vert_x, got.vert_x);
    check_field("y", want.vert_y, got.vert_y);
    check_field("z", want.vert_z, got.vert_z);
    check_field("face", 8'(want.face_dir), 8'(got.face_dir));
    check_field("red", want.red, got.red);
    check_field("green", want.green, got.green);
    check_field("blue", want.blue, got.blue);
    check_field("last", 8'(want.last_vertex), 8'(got.last_vertex));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = vfcm_pkg::GRID_WIDTH_RST;
      height_reg = vfcm_pkg::GRID_HEIGHT_RST;
      scale_reg  = vfcm_pkg::VERTEX_SCALE_RST;
      vertex_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          vfcm_pkg::REG_GRID_WIDTH:   width_reg  = pwdata[5:0];
          vfcm_pkg::REG_GRID_HEIGHT:  height_reg = pwdata[6:0];
          vfcm_pkg::REG_VERTEX_SCALE: scale_reg  = pwdata[6:0];
          default: ;
        endcase
      end
      if (vtx_valid && vtx_ready) check_vertex(vtx_word);
      if (cmd_valid && cmd_ready) take_word(cmd_word);
    end
    vertices_pending <= vertex_queue.size();
    mismatch_count   <= mismatches;
  end

endmodule

// ===== tb/tb_voxel_face_cull_mesher_unit.sv =====
// tb_voxel_face_cull_mesher_unit: stimulus and verdict for the voxel face mesher
// drives command words and register writes, stalls the vertex sink, and relies on
// vfcm_vertex_checker (and vfcm_pkg) for prediction and comparison

module tb_voxel_face_cull_mesher_unit;

  localparam int MAX_W     = 32;
  localparam int MAX_H     = 64;
  localparam int PAL_DEPTH = 255;
  localparam int CELLS     = MAX_W * MAX_W * MAX_H;

  // the one command code the block leaves unused
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // margin past the longest mesh before touching registers
  localparam int SETTLE_CYCLES = 60;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  vfcm_pkg::vfcm_in_t  cmd_word  = '0;
  logic                vtx_valid;
  logic                vtx_ready = 1'b0;
  vfcm_pkg::vfcm_out_t vtx_word;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [3:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  mismatch_count;
  int                  vertices_pending;

  // random gaps on both sides while set
  bit idling    = 1'b1;
  int sink_hold = 0;
  int words_sent = 0;

  // raw register values as last written
  int grid_w = int'(vfcm_pkg::GRID_WIDTH_RST);
  int grid_h = int'(vfcm_pkg::GRID_HEIGHT_RST);

  // what the stimulus has put in the voxel store and palette, so that a mesh word
  // never makes the block read an entry that was never written
  bit         cell_set [0:CELLS-1];
  logic [7:0] cell_id  [0:CELLS-1];
  bit         slot_set [0:PAL_DEPTH-1];

  voxel_face_cull_mesher_unit #(
    .MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_word(cmd_word),
    .vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx_word(vtx_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vfcm_vertex_checker #(
    .MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .PALETTE_DEPTH(PAL_DEPTH)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_word(cmd_word),
    .vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx_word(vtx_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .vertices_pending(vertices_pending)
  );

  always #5 clk = ~clk;

  // vertex sink: ready most of the time, with stall bursts while gaps are on
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      vtx_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 6) == 0) begin
      sink_hold <= $urandom_range(0, 4);
      vtx_ready <= 1'b0;
    end else begin
      vtx_ready <= 1'b1;
    end
  end

  // effective grid, registers above the store size saturate
  function automatic int eff_w();
    return (grid_w > MAX_W) ? MAX_W : grid_w;
  endfunction

  function automatic int eff_h();
    return (grid_h > MAX_H) ? MAX_H : grid_h;
  endfunction

  function automatic int cell_at(input int x, input int y, input int z);
    return (x * MAX_W + z) * MAX_H + y;
  endfunction

  // fields a command ignores still carry random bits
  function automatic vfcm_pkg::vfcm_in_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(vfcm_pkg::vfcm_in_t)-1:0];
  endfunction

  // empty cells often enough that neighbourhoods come out mixed
  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 9) < 4) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  // one command word; valid stays up across back-to-back words
  task automatic send_word(input vfcm_pkg::vfcm_in_t word);
    if (idling && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= word;
    do @(posedge clk); while (!cmd_ready);
    words_sent++;
  endtask

  // hold the sender off until every expected vertex is out and the block has settled
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (vertices_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_config(input int w, input int h, input int s);
    drain();
    write_reg(vfcm_pkg::REG_GRID_WIDTH, w);
    write_reg(vfcm_pkg::REG_GRID_HEIGHT, h);
    write_reg(vfcm_pkg::REG_VERTEX_SCALE, s);
    grid_w = w;
    grid_h = h;
  endtask

  task automatic put_voxel(input int x, input int y, input int z, input logic [7:0] id);
    vfcm_pkg::vfcm_in_t word;
    word          = rand_word();
    word.command  = vfcm_pkg::CMD_VOXEL_WR;
    word.pos_x    = x[4:0];
    word.pos_y    = y[5:0];
    word.pos_z    = z[4:0];
    word.block_id = id;
    send_word(word);
    cell_set[cell_at(x, y, z)] = 1'b1;
    cell_id[cell_at(x, y, z)]  = id;
  endtask

  task automatic put_colour(input int idx, input logic [23:0] rgb);
    vfcm_pkg::vfcm_in_t word;
    word               = rand_word();
    word.command       = vfcm_pkg::CMD_PALETTE_WR;
    word.palette_index = idx[7:0];
    word.color_rgb     = rgb;
    send_word(word);
    if (idx < PAL_DEPTH) slot_set[idx] = 1'b1;
  endtask

  task automatic send_spare();
    vfcm_pkg::vfcm_in_t word;
    word         = rand_word();
    word.command = CMD_SPARE;
    send_word(word);
  endtask

  task automatic prep_cell(input int x, input int y, input int z);
    if (!cell_set[cell_at(x, y, z)]) put_voxel(x, y, z, pick_id());
  endtask

  // mesh one cell; inside the grid, first fill whatever the block will read:
  // the centre, the neighbours inside the grid and the colour slot
  task automatic mesh_at(input int x, input int y, input int z);
    vfcm_pkg::vfcm_in_t word;
    int                 w, h;
    logic [7:0]         id;
    w = eff_w();
    h = eff_h();
    if (x < w && z < w && y < h) begin
      prep_cell(x, y, z);
      id = cell_id[cell_at(x, y, z)];
      if (id != 8'd0) begin
        if (y + 1 < h) prep_cell(x, y + 1, z);
        if (x + 1 < w) prep_cell(x + 1, y, z);
        if (z + 1 < w) prep_cell(x, y, z + 1);
        if (y > 0) prep_cell(x, y - 1, z);
        if (x > 0) prep_cell(x - 1, y, z);
        if (z > 0) prep_cell(x, y, z - 1);
        if (!slot_set[int'(id) - 1]) put_colour(int'(id) - 1, 24'($urandom));
      end
    end
    word         = rand_word();
    word.command = vfcm_pkg::CMD_MESH;
    word.pos_x   = x[4:0];
    word.pos_y   = y[5:0];
    word.pos_z   = z[4:0];
    send_word(word);
  endtask

  // a cell in the grid (half the time in a corner box so neighbours get reused),
  // or anywhere in the store
  task automatic pick_cell(input bit in_grid, output int x, output int y, output int z);
    int w, h;
    w = eff_w();
    h = eff_h();
    if (!in_grid || w == 0 || h == 0) begin
      x = $urandom_range(0, MAX_W - 1);
      y = $urandom_range(0, MAX_H - 1);
      z = $urandom_range(0, MAX_W - 1);
    end else if ($urandom_range(0, 1) == 1) begin
      x = $urandom_range(0, (w < 4 ? w : 4) - 1);
      y = $urandom_range(0, (h < 4 ? h : 4) - 1);
      z = $urandom_range(0, (w < 4 ? w : 4) - 1);
    end else begin
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
      z = $urandom_range(0, w - 1);
    end
  endtask

  // mostly prepared mesh words, then grid edits, palette writes and the odd spare code
  task automatic random_op();
    int pick, x, y, z;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick_cell(pick < 47, x, y, z);
      mesh_at(x, y, z);
    end else if (pick < 80) begin
      pick_cell(pick < 72, x, y, z);
      put_voxel(x, y, z, pick_id());
    end else if (pick < 95) begin
      put_colour($urandom_range(0, 255), 24'($urandom));
    end else begin
      send_spare();
    end
  endtask

  task automatic run_phase(input int w, input int h, input int s, input int budget,
                           input bit idle_on, input bit pause_mid);
    int start;
    set_config(w, h, s);
    idling = idle_on;
    start  = words_sent;
    while (words_sent - start < budget) begin
      random_op();
      if (pause_mid && words_sent - start >= budget / 2) begin
        pause_mid = 1'b0;
        drain();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // palette write past the last slot and the spare code, both ignored
    put_colour(PAL_DEPTH, 24'($urandom));
    send_spare();

    // isolated cell in the corner at the origin, white, all six faces
    put_colour(0, 24'hFFFFFF);
    put_voxel(0, 0, 0, 8'd1);
    put_voxel(1, 0, 0, 8'd0);
    put_voxel(0, 1, 0, 8'd0);
    put_voxel(0, 0, 1, 8'd0);
    mesh_at(0, 0, 0);

    // isolated cell in the far corner with the highest id and last slot
    put_colour(PAL_DEPTH - 1, 24'h5AC30F);
    put_voxel(31, 63, 31, 8'd255);
    put_voxel(30, 63, 31, 8'd0);
    put_voxel(31, 62, 31, 8'd0);
    put_voxel(31, 63, 30, 8'd0);
    mesh_at(31, 63, 31);

    // empty cell gives nothing
    put_voxel(5, 5, 5, 8'd0);
    mesh_at(5, 5, 5);

    // registers above the store size, largest scale so x and z wrap
    set_config(63, 127, 127);
    mesh_at(31, 63, 31);
    mesh_at(0, 0, 0);

    // smallest non-empty grid and zero scale; the next cell along lies outside
    set_config(1, 1, 0);
    mesh_at(0, 0, 0);
    mesh_at(1, 0, 0);

    // zero width leaves no cell in use
    set_config(0, 64, 5);
    mesh_at(0, 0, 0);

    // random phases: small and full grids, saturating and zero registers,
    // two stretches without gaps, the last at the finish, and one mid-phase drain
    run_phase(4, 4, 3, 40, 1'b1, 1'b0);
    run_phase(32, 64, 127, 30, 1'b1, 1'b0);
    run_phase(2, 8, 0, 25, 1'b0, 1'b0);
    run_phase(40, 100, 1, 25, 1'b1, 1'b0);
    run_phase(3, 0, 64, 10, 1'b1, 1'b0);
    run_phase(6, 5, 77, 40, 1'b1, 1'b1);
    run_phase(5, 3, 1, 40, 1'b0, 1'b0);

    drain();
    if (mismatch_count == 0 && vertices_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(64'd15_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
